// ----- rtl/core/led_display_two_wire_writer_macros.svh -----
// Assertion macros shared by the two-wire LED display writer RTL.
`ifndef LED_DISPLAY_TWO_WIRE_WRITER_MACROS_SVH
`define LED_DISPLAY_TWO_WIRE_WRITER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LDDW_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LDDW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- rtl/core/lddw_pkg.sv -----
// Types, codes and constants for the two-wire LED display writer.
package lddw_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned NUM_DIGITS = 4;
    localparam int unsigned DIGIT_IDX_W = $clog2(NUM_DIGITS);
    localparam int unsigned BIT_CNT_W  = $clog2(BYTE_W);
    localparam int unsigned CMD_W      = 2;
    localparam int unsigned CFG_IDX_W  = 3;

    // Command codes on the input channel
    localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INIT    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DISPLAY = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE_CMD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SETTING  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIGIT0   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIGIT1   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIGIT2   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DIGIT3   = 3'd5;

    // Configuration reset values
    localparam logic [BYTE_W-1:0] MODE_CMD_RST = 8'd72;
    localparam logic [BYTE_W-1:0] SETTING_RST  = 8'd1;
    localparam logic [BYTE_W-1:0] DIGIT0_RST   = 8'd104;
    localparam logic [BYTE_W-1:0] DIGIT1_RST   = 8'd106;
    localparam logic [BYTE_W-1:0] DIGIT2_RST   = 8'd108;
    localparam logic [BYTE_W-1:0] DIGIT3_RST   = 8'd110;

    localparam logic [DIGIT_IDX_W-1:0] LAST_DIGIT = DIGIT_IDX_W'(NUM_DIGITS - 1);
    localparam logic [BIT_CNT_W-1:0]   LAST_BIT   = BIT_CNT_W'(BYTE_W - 1);

    // Pin phases of one transaction
    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_START_D = 4'd1,
        PH_START_C = 4'd2,
        PH_BIT_D   = 4'd3,
        PH_BIT_CH  = 4'd4,
        PH_BIT_CL  = 4'd5,
        PH_ACK_D   = 4'd6,
        PH_ACK_CH  = 4'd7,
        PH_ACK_CL  = 4'd8,
        PH_STOP_C  = 4'd9,
        PH_STOP_D  = 4'd10
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0]                  mode_cmd;
        logic [BYTE_W-1:0]                  setting;
        logic [NUM_DIGITS-1:0][BYTE_W-1:0]  digit_addr;
    } lddw_cfg_t;

    typedef struct packed {
        logic clock_line;
        logic data_line;
        logic busy_res;
        logic sequence_done;
        logic request_ignored;
    } lddw_result_t;

endpackage

// ----- rtl/core/lddw_cfg_regs.sv -----
// Configuration register file: mode, setting and digit address bytes.
module lddw_cfg_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [lddw_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lddw_pkg::BYTE_W-1:0]        cfg_wr_data,
    output lddw_pkg::lddw_cfg_t                cfg
);

    lddw_pkg::lddw_cfg_t cfg_reg;

    // Writes to an index beyond the list fall into the default arm
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode_cmd      <= lddw_pkg::MODE_CMD_RST;
            cfg_reg.setting       <= lddw_pkg::SETTING_RST;
            cfg_reg.digit_addr[0] <= lddw_pkg::DIGIT0_RST;
            cfg_reg.digit_addr[1] <= lddw_pkg::DIGIT1_RST;
            cfg_reg.digit_addr[2] <= lddw_pkg::DIGIT2_RST;
            cfg_reg.digit_addr[3] <= lddw_pkg::DIGIT3_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                lddw_pkg::REG_MODE_CMD: cfg_reg.mode_cmd      <= cfg_wr_data;
                lddw_pkg::REG_SETTING:  cfg_reg.setting       <= cfg_wr_data;
                lddw_pkg::REG_DIGIT0:   cfg_reg.digit_addr[0] <= cfg_wr_data;
                lddw_pkg::REG_DIGIT1:   cfg_reg.digit_addr[1] <= cfg_wr_data;
                lddw_pkg::REG_DIGIT2:   cfg_reg.digit_addr[2] <= cfg_wr_data;
                lddw_pkg::REG_DIGIT3:   cfg_reg.digit_addr[3] <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/core/lddw_engine.sv -----
// Pin phase sequencer: start, eight bits plus dummy ack per byte, stop.
module lddw_engine (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                step,
    input  logic [lddw_pkg::CMD_W-1:0]          cmd,
    input  logic [lddw_pkg::BYTE_W-1:0]         digit_a,
    input  logic [lddw_pkg::BYTE_W-1:0]         digit_b,
    input  logic [lddw_pkg::BYTE_W-1:0]         digit_c,
    input  logic [lddw_pkg::BYTE_W-1:0]         digit_d,
    input  lddw_pkg::lddw_cfg_t                 cfg,
    output lddw_pkg::lddw_result_t              result
);

    lddw_pkg::phase_t                        phase_reg, phase_next;
    logic [lddw_pkg::BIT_CNT_W-1:0]          bit_count_reg, bit_count_next;
    logic [lddw_pkg::BYTE_W-1:0]             shift_byte_reg, shift_byte_next;
    logic [lddw_pkg::DIGIT_IDX_W-1:0]        txn_index_reg, txn_index_next;
    logic                                    second_byte_reg, second_byte_next;
    logic                                    job_display_reg, job_display_next;
    logic                                    clock_level_reg, clock_level_next;
    logic                                    data_level_reg, data_level_next;
    logic                                    digit_wr;
    logic [lddw_pkg::BYTE_W-1:0]             digit_store_reg [lddw_pkg::NUM_DIGITS];
    logic [lddw_pkg::BYTE_W-1:0]             first_byte, second_byte;
    logic                                    done, ignored;

    // Bytes of the current transaction
    assign first_byte  = job_display_reg ? cfg.digit_addr[txn_index_reg] : cfg.mode_cmd;
    assign second_byte = job_display_reg ? digit_store_reg[txn_index_reg] : cfg.setting;

    // Next state and result flags
    always_comb begin
        phase_next       = phase_reg;
        bit_count_next   = bit_count_reg;
        shift_byte_next  = shift_byte_reg;
        txn_index_next   = txn_index_reg;
        second_byte_next = second_byte_reg;
        job_display_next = job_display_reg;
        clock_level_next = clock_level_reg;
        data_level_next  = data_level_reg;
        digit_wr         = 1'b0;
        done             = 1'b0;
        ignored          = 1'b0;
        case (cmd)
            lddw_pkg::CMD_INIT, lddw_pkg::CMD_DISPLAY: begin
                if (phase_reg != lddw_pkg::PH_IDLE) begin
                    ignored = 1'b1;
                end else begin
                    job_display_next = (cmd == lddw_pkg::CMD_DISPLAY);
                    digit_wr         = (cmd == lddw_pkg::CMD_DISPLAY);
                    txn_index_next   = '0;
                    second_byte_next = 1'b0;
                    bit_count_next   = '0;
                    phase_next       = lddw_pkg::PH_START_D;
                end
            end
            lddw_pkg::CMD_TICK: begin
                case (phase_reg)
                    lddw_pkg::PH_IDLE: ;
                    lddw_pkg::PH_START_D: begin
                        data_level_next = 1'b0;
                        phase_next      = lddw_pkg::PH_START_C;
                    end
                    lddw_pkg::PH_START_C: begin
                        clock_level_next = 1'b0;
                        shift_byte_next  = first_byte;
                        bit_count_next   = '0;
                        second_byte_next = 1'b0;
                        phase_next       = lddw_pkg::PH_BIT_D;
                    end
                    lddw_pkg::PH_BIT_D: begin
                        data_level_next = shift_byte_reg[lddw_pkg::BYTE_W-1];
                        phase_next      = lddw_pkg::PH_BIT_CH;
                    end
                    lddw_pkg::PH_BIT_CH: begin
                        clock_level_next = 1'b1;
                        phase_next       = lddw_pkg::PH_BIT_CL;
                    end
                    lddw_pkg::PH_BIT_CL: begin
                        clock_level_next = 1'b0;
                        shift_byte_next  = {shift_byte_reg[lddw_pkg::BYTE_W-2:0], 1'b0};
                        if (bit_count_reg == lddw_pkg::LAST_BIT) begin
                            bit_count_next = '0;
                            phase_next     = lddw_pkg::PH_ACK_D;
                        end else begin
                            bit_count_next = bit_count_reg + 1'b1;
                            phase_next     = lddw_pkg::PH_BIT_D;
                        end
                    end
                    lddw_pkg::PH_ACK_D: begin
                        data_level_next = 1'b0;
                        phase_next      = lddw_pkg::PH_ACK_CH;
                    end
                    lddw_pkg::PH_ACK_CH: begin
                        clock_level_next = 1'b1;
                        phase_next       = lddw_pkg::PH_ACK_CL;
                    end
                    lddw_pkg::PH_ACK_CL: begin
                        clock_level_next = 1'b0;
                        if (!second_byte_reg) begin
                            second_byte_next = 1'b1;
                            shift_byte_next  = second_byte;
                            bit_count_next   = '0;
                            phase_next       = lddw_pkg::PH_BIT_D;
                        end else begin
                            phase_next = lddw_pkg::PH_STOP_C;
                        end
                    end
                    lddw_pkg::PH_STOP_C: begin
                        clock_level_next = 1'b1;
                        phase_next       = lddw_pkg::PH_STOP_D;
                    end
                    lddw_pkg::PH_STOP_D: begin
                        data_level_next = 1'b1;
                        if (job_display_reg && (txn_index_reg != lddw_pkg::LAST_DIGIT)) begin
                            txn_index_next = txn_index_reg + 1'b1;
                            phase_next     = lddw_pkg::PH_START_D;
                        end else begin
                            txn_index_next = '0;
                            phase_next     = lddw_pkg::PH_IDLE;
                            done           = 1'b1;
                        end
                    end
                    default: phase_next = lddw_pkg::PH_IDLE;
                endcase
            end
            default: ;
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= lddw_pkg::PH_IDLE;
            bit_count_reg   <= '0;
            shift_byte_reg  <= '0;
            txn_index_reg   <= '0;
            second_byte_reg <= 1'b0;
            job_display_reg <= 1'b0;
            clock_level_reg <= 1'b1;
            data_level_reg  <= 1'b1;
        end else if (step) begin
            phase_reg       <= phase_next;
            bit_count_reg   <= bit_count_next;
            shift_byte_reg  <= shift_byte_next;
            txn_index_reg   <= txn_index_next;
            second_byte_reg <= second_byte_next;
            job_display_reg <= job_display_next;
            clock_level_reg <= clock_level_next;
            data_level_reg  <= data_level_next;
        end
    end

    // Digit bytes latched on an accepted display request
    always_ff @(posedge aclk) begin
        if (step && digit_wr) begin
            digit_store_reg[0] <= digit_a;
            digit_store_reg[1] <= digit_b;
            digit_store_reg[2] <= digit_c;
            digit_store_reg[3] <= digit_d;
        end
    end

    // Pin levels and flags after this transfer
    always_comb begin
        result.clock_line      = clock_level_next;
        result.data_line       = data_level_next;
        result.busy_res        = (phase_next != lddw_pkg::PH_IDLE);
        result.sequence_done   = done;
        result.request_ignored = ignored;
    end

endmodule

// ----- rtl/core/lddw_out_stage.sv -----
// Result register with a skid entry so input and output stalls are decoupled.
module lddw_out_stage (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_fire,
    input  lddw_pkg::lddw_result_t    in_data,
    output logic                      in_ready,
    output logic                      out_valid,
    input  logic                      out_ready,
    output lddw_pkg::lddw_result_t    out_data
);

    logic                     main_valid_reg;
    logic                     skid_valid_reg;
    lddw_pkg::lddw_result_t   main_data_reg;
    lddw_pkg::lddw_result_t   skid_data_reg;

    // Valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (main_valid_reg && !out_ready) begin
            if (in_fire) begin
                skid_valid_reg <= 1'b1;
            end
        end else begin
            main_valid_reg <= skid_valid_reg || in_fire;
            skid_valid_reg <= 1'b0;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (main_valid_reg && !out_ready) begin
            if (in_fire) begin
                skid_data_reg <= in_data;
            end
        end else if (skid_valid_reg) begin
            main_data_reg <= skid_data_reg;
        end else if (in_fire) begin
            main_data_reg <= in_data;
        end
    end

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

endmodule

// ----- rtl/core/led_display_two_wire_writer.sv -----
// A transfer's result is registered in the result stage before it appears on the m_ side.
// Throughput: one input transfer per cycle while s_ready is high; the phase engine state is registered per transfer.
// A two-entry result stage keeps s_ready high while one result waits on m_ready.
// Reset (aresetn low, synchronous): engine idle, both pins high, config at defaults.
// The digit store has no reset; it is written by every display request that starts a sequence, before use.
module led_display_two_wire_writer (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [lddw_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lddw_pkg::BYTE_W-1:0]        cfg_wr_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [lddw_pkg::CMD_W-1:0]         s_cmd,
    input  logic [lddw_pkg::BYTE_W-1:0]        s_digit_a,
    input  logic [lddw_pkg::BYTE_W-1:0]        s_digit_b,
    input  logic [lddw_pkg::BYTE_W-1:0]        s_digit_c,
    input  logic [lddw_pkg::BYTE_W-1:0]        s_digit_d,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_clock_line,
    output logic                               m_data_line,
    output logic                               m_busy_res,
    output logic                               m_sequence_done,
    output logic                               m_request_ignored
);

`include "led_display_two_wire_writer_macros.svh"

    lddw_pkg::lddw_cfg_t      cfg;
    lddw_pkg::lddw_result_t   eng_result;
    lddw_pkg::lddw_result_t   out_result;
    logic                     in_fire;

    assign in_fire = s_valid && s_ready;

    // Configuration registers
    lddw_cfg_regs u_cfg_regs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    // Phase sequencer, advanced once per accepted transfer
    lddw_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (in_fire),
        .cmd     (s_cmd),
        .digit_a (s_digit_a),
        .digit_b (s_digit_b),
        .digit_c (s_digit_c),
        .digit_d (s_digit_d),
        .cfg     (cfg),
        .result  (eng_result)
    );

    // Result register and skid entry
    lddw_out_stage u_out_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .in_data   (eng_result),
        .in_ready  (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_result)
    );

    assign m_clock_line      = out_result.clock_line;
    assign m_data_line       = out_result.data_line;
    assign m_busy_res        = out_result.busy_res;
    assign m_sequence_done   = out_result.sequence_done;
    assign m_request_ignored = out_result.request_ignored;

    // Checks on the result stream and the skid stage
    `LDDW_ASSERT_SAME(a_done_not_busy, aclk, aresetn, m_valid && m_sequence_done, !m_busy_res)
    `LDDW_ASSERT_SAME(a_ignored_busy, aclk, aresetn, m_valid && m_request_ignored, m_busy_res)
    `LDDW_ASSERT_SAME(a_idle_bus_high, aclk, aresetn, m_valid && !m_busy_res, m_clock_line && m_data_line)
    `LDDW_ASSERT_SAME(a_skid_needs_main, aclk, aresetn, !s_ready, m_valid)
    `LDDW_ASSERT_NEXT(a_stall_holds_skid, aclk, aresetn, !s_ready && !m_ready, !s_ready)

endmodule
